@@ sv/lpic_pkg.sv @@
// shared types and constants for the linked pool insert and min collect block
`timescale 1ns / 1ps
`default_nettype none
package lpic_pkg;

   localparam int ID_W    = 32;
   localparam int GRADE_W = 16;
   localparam int SLOT_W  = 4;

   // pool size, every slot must fit the 4-bit slot fields
   localparam int POOL_NODES = 16;

   // request function codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_FIND   = 1'b1;

   typedef struct packed {
      logic signed [ID_W-1:0]    id;
      logic signed [GRADE_W-1:0] grade;
   } node_data_type;

   localparam logic signed [ID_W-1:0]    RESET_ID    = -32'sd1;
   localparam logic signed [GRADE_W-1:0] RESET_GRADE = -16'sd10;

endpackage
`default_nettype wire

@@ sv/lpic_node_mem.sv @@
// node payload memory (id and grade), one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module lpic_node_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  lpic_pkg::node_data_type wr_data,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output lpic_pkg::node_data_type rd_data
);
   import lpic_pkg::*;

   node_data_type mem_ff [DEPTH];
   node_data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/lpic_link_mem.sv @@
// next-link memory, one write and two registered read ports
`timescale 1ns / 1ps
`default_nettype none
module lpic_link_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int W     = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic          rd_a_en,
   input  logic [AW-1:0] rd_a_addr,
   output logic [W-1:0]  rd_a_data,
   input  logic          rd_b_en,
   input  logic [AW-1:0] rd_b_addr,
   output logic [W-1:0]  rd_b_data
);

   logic [W-1:0] mem_ff [DEPTH];
   logic [W-1:0] rd_a_ff;
   logic [W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule
`default_nettype wire

@@ sv/lpic_tie_stack.sv @@
// stack memory for ids that tie on the minimum grade
`timescale 1ns / 1ps
`default_nettype none
module lpic_tie_stack #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [AW-1:0]                     wr_addr,
   input  logic signed [lpic_pkg::ID_W-1:0]  wr_data,
   input  logic                              rd_en,
   input  logic [AW-1:0]                     rd_addr,
   output logic signed [lpic_pkg::ID_W-1:0]  rd_data
);
   import lpic_pkg::*;

   logic signed [ID_W-1:0] mem_ff [DEPTH];
   logic signed [ID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/linked_pool_insert_and_min_collect_core.sv @@
// top level: node pool with free list, insert and minimum-grade collection
`timescale 1ns / 1ps
`default_nettype none
// Node pool of POOL_NODES slots kept as an array linked list plus a free list.
// An insert request takes the free-list head, stores id and grade, and links
// the node at the list head or after pred_index (a predecessor outside the pool
// means head); it answers with one response carrying the slot, or full_res when
// no node is free. A find request walks the list from its head, at most
// POOL_NODES nodes, tracking the minimum grade and stacking up to TIE_DEPTH ids
// that hold it; it then answers with one response per stacked id, last pushed
// first, with last set on the final one, or one response with empty_res for an
// empty list. After reset a clearing pass over all POOL_NODES slots initializes the
// pool memories; req_stall stays high during it. Steps per request: insert
// runs accept, link read and write, predecessor write (only after a
// predecessor) and response load; find walks the list one node after
// another, bound by the registered read of the link memory since each
// address comes from the previous read, then pops each response from the
// single stack read port before emitting it. A full output register holds a
// response while rsp_stall is high; the next request is accepted as soon as
// the engine is back in idle.
module linked_pool_insert_and_min_collect_core #(
   parameter int TIE_DEPTH  = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic signed [lpic_pkg::ID_W-1:0]      req_new_id,
   input  logic signed [lpic_pkg::GRADE_W-1:0]   req_new_grade,
   input  logic                                  req_pred_valid,
   input  logic [lpic_pkg::SLOT_W-1:0]           req_pred_index,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lpic_pkg::SLOT_W-1:0]           rsp_slot_index,
   output logic                                  rsp_full_res,
   output logic                                  rsp_empty_res,
   output logic signed [lpic_pkg::GRADE_W-1:0]   rsp_min_grade,
   output logic signed [lpic_pkg::ID_W-1:0]      rsp_student_id,
   output logic                                  rsp_last
);
   import lpic_pkg::*;

   localparam int IDX_W  = $clog2(POOL_NODES);
   localparam int LINK_W = $clog2(POOL_NODES + 1);
   localparam int TIE_AW = (TIE_DEPTH > 1) ? $clog2(TIE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TIE_DEPTH + 1);
   // nil link is encoded as the pool size
   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_NODES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_LINK,
      ST_INS_PRED,
      ST_REPLY,
      ST_WALK,
      ST_POP,
      ST_EMIT
   } state_type;

   // control and datapath registers
   state_type                 state_ff,     state_in;
   logic [IDX_W-1:0]          clr_cnt_ff,   clr_cnt_in;
   logic [LINK_W-1:0]         free_head_ff, free_head_in;
   logic [LINK_W-1:0]         list_head_ff, list_head_in;
   logic [IDX_W-1:0]          slot_ff,      slot_in;
   logic [IDX_W-1:0]          pred_ff,      pred_in;
   logic                      use_pred_ff,  use_pred_in;
   logic                      full_ff,      full_in;
   logic                      empty_ff,     empty_in;
   logic [LINK_W-1:0]         steps_ff,     steps_in;
   logic signed [GRADE_W-1:0] mn_ff,        mn_in;
   logic [CNT_W-1:0]          count_ff,     count_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]         rsp_slot_ff,  rsp_slot_in;
   logic                      rsp_full_ff,  rsp_full_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic signed [GRADE_W-1:0] rsp_grade_ff, rsp_grade_in;
   logic signed [ID_W-1:0]    rsp_id_ff,    rsp_id_in;
   logic                      rsp_last_ff,  rsp_last_in;

   // memory ports
   logic                      node_we, node_re;
   logic [IDX_W-1:0]          node_wa, node_ra;
   node_data_type             node_wd, node_rd;
   logic                      link_we, link_re_a, link_re_b;
   logic [IDX_W-1:0]          link_wa, link_ra_a, link_ra_b;
   logic [LINK_W-1:0]         link_wd, link_rd_a, link_rd_b;
   logic                      tie_we, tie_re;
   logic [TIE_AW-1:0]         tie_wa, tie_ra;
   logic signed [ID_W-1:0]    tie_wd, tie_rd;

   logic                      out_free;
   logic                      walk_lt;
   logic                      walk_eq;
   logic                      walk_done;

   lpic_node_mem #(
      .DEPTH (POOL_NODES),
      .AW    (IDX_W)
   ) u_node_mem (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_wa),
      .wr_data (node_wd),
      .rd_en   (node_re),
      .rd_addr (node_ra),
      .rd_data (node_rd)
   );

   lpic_link_mem #(
      .DEPTH (POOL_NODES),
      .AW    (IDX_W),
      .W     (LINK_W)
   ) u_link_mem (
      .clock     (clock),
      .wr_en     (link_we),
      .wr_addr   (link_wa),
      .wr_data   (link_wd),
      .rd_a_en   (link_re_a),
      .rd_a_addr (link_ra_a),
      .rd_a_data (link_rd_a),
      .rd_b_en   (link_re_b),
      .rd_b_addr (link_ra_b),
      .rd_b_data (link_rd_b)
   );

   lpic_tie_stack #(
      .DEPTH (TIE_DEPTH),
      .AW    (TIE_AW)
   ) u_tie_stack (
      .clock   (clock),
      .wr_en   (tie_we),
      .wr_addr (tie_wa),
      .wr_data (tie_wd),
      .rd_en   (tie_re),
      .rd_addr (tie_ra),
      .rd_data (tie_rd)
   );

   // output register can take a new response this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // walk compares: the first node always restarts the minimum
   assign walk_lt   = (steps_ff == '0) || (node_rd.grade < mn_ff);
   assign walk_eq   = (node_rd.grade == mn_ff);
   assign walk_done = (link_rd_a >= NIL_LINK) ||
                      (steps_ff == LINK_W'(POOL_NODES - 1));

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      free_head_in = free_head_ff;
      list_head_in = list_head_ff;
      slot_in      = slot_ff;
      pred_in      = pred_ff;
      use_pred_in  = use_pred_ff;
      full_in      = full_ff;
      empty_in     = empty_ff;
      steps_in     = steps_ff;
      mn_in        = mn_ff;
      count_in     = count_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_slot_in  = rsp_slot_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_grade_in = rsp_grade_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;

      node_we   = 1'b0;
      node_wa   = '0;
      node_wd   = '0;
      node_re   = 1'b0;
      node_ra   = '0;
      link_we   = 1'b0;
      link_wa   = '0;
      link_wd   = '0;
      link_re_a = 1'b0;
      link_ra_a = '0;
      link_re_b = 1'b0;
      link_ra_b = '0;
      tie_we    = 1'b0;
      tie_wa    = '0;
      tie_wd    = node_rd.id;
      tie_re    = 1'b0;
      tie_ra    = '0;

      case (state_ff)
         ST_CLEAR: begin
            // slot i gets reset payload and links to i + 1, last slot to nil
            node_we = 1'b1;
            node_wa = clr_cnt_ff;
            node_wd = '{id: RESET_ID, grade: RESET_GRADE};
            link_we = 1'b1;
            link_wa = clr_cnt_ff;
            link_wd = LINK_W'(clr_cnt_ff) + LINK_W'(1);
            if (clr_cnt_ff == IDX_W'(POOL_NODES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               full_in  = 1'b0;
               empty_in = 1'b0;
               slot_in  = '0;
               if (req_func == FUNC_INSERT) begin
                  if (free_head_ff >= NIL_LINK) begin
                     // pool exhausted, nothing changes
                     full_in  = 1'b1;
                     state_in = ST_REPLY;
                  end else begin
                     node_we     = 1'b1;
                     node_wa     = free_head_ff[IDX_W-1:0];
                     node_wd     = '{id: req_new_id, grade: req_new_grade};
                     link_re_a   = 1'b1;
                     link_ra_a   = free_head_ff[IDX_W-1:0];
                     link_re_b   = 1'b1;
                     link_ra_b   = IDX_W'(req_pred_index);
                     slot_in     = free_head_ff[IDX_W-1:0];
                     pred_in     = IDX_W'(req_pred_index);
                     use_pred_in = req_pred_valid &&
                                   (32'(req_pred_index) < POOL_NODES);
                     state_in    = ST_INS_LINK;
                  end
               end else begin
                  if (list_head_ff >= NIL_LINK) begin
                     empty_in = 1'b1;
                     state_in = ST_REPLY;
                  end else begin
                     node_re   = 1'b1;
                     node_ra   = list_head_ff[IDX_W-1:0];
                     link_re_a = 1'b1;
                     link_ra_a = list_head_ff[IDX_W-1:0];
                     steps_in  = '0;
                     count_in  = '0;
                     state_in  = ST_WALK;
                  end
               end
            end
         end

         ST_INS_LINK: begin
            // old link of the taken node becomes the free-list head
            free_head_in = (link_rd_a >= NIL_LINK) ? NIL_LINK : link_rd_a;
            link_we      = 1'b1;
            link_wa      = slot_ff;
            if (use_pred_ff) begin
               link_wd  = link_rd_b;
               state_in = ST_INS_PRED;
            end else begin
               link_wd      = list_head_ff;
               list_head_in = LINK_W'(slot_ff);
               state_in     = ST_REPLY;
            end
         end

         ST_INS_PRED: begin
            // written after the new node's link, so a self loop wins
            link_we  = 1'b1;
            link_wa  = pred_ff;
            link_wd  = LINK_W'(slot_ff);
            state_in = ST_REPLY;
         end

         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = SLOT_W'(slot_ff);
               rsp_full_in  = full_ff;
               rsp_empty_in = empty_ff;
               rsp_grade_in = '0;
               rsp_id_in    = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_WALK: begin
            if (walk_lt) begin
               mn_in    = node_rd.grade;
               tie_we   = 1'b1;
               tie_wa   = '0;
               count_in = CNT_W'(1);
            end else if (walk_eq && (count_ff < CNT_W'(TIE_DEPTH))) begin
               tie_we   = 1'b1;
               tie_wa   = TIE_AW'(count_ff);
               count_in = count_ff + 1'b1;
            end
            steps_in = steps_ff + 1'b1;
            if (walk_done) begin
               state_in = ST_POP;
            end else begin
               node_re   = 1'b1;
               node_ra   = link_rd_a[IDX_W-1:0];
               link_re_a = 1'b1;
               link_ra_a = link_rd_a[IDX_W-1:0];
            end
         end

         ST_POP: begin
            tie_re   = 1'b1;
            tie_ra   = TIE_AW'(count_ff - 1'b1);
            count_in = count_ff - 1'b1;
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = '0;
               rsp_full_in  = 1'b0;
               rsp_empty_in = 1'b0;
               rsp_grade_in = mn_ff;
               rsp_id_in    = tie_rd;
               rsp_last_in  = (count_ff == '0);
               state_in     = (count_ff == '0) ? ST_IDLE : ST_POP;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      pred_ff      <= pred_in;
      use_pred_ff  <= use_pred_in;
      full_ff      <= full_in;
      empty_ff     <= empty_in;
      steps_ff     <= steps_in;
      mn_ff        <= mn_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_grade_ff <= rsp_grade_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         free_head_ff <= '0;
         list_head_ff <= NIL_LINK;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         free_head_ff <= free_head_in;
         list_head_ff <= list_head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // only idle takes requests
   assign req_stall = (state_ff != ST_IDLE);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_full_res   = rsp_full_ff;
   assign rsp_empty_res  = rsp_empty_ff;
   assign rsp_min_grade  = rsp_grade_ff;
   assign rsp_student_id = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;

   // walk never exceeds the pool size
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> steps_ff < LINK_W'(POOL_NODES))
      else $error("walk step count out of range");

   // stack never overfills
   a_tie_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TIE_DEPTH))
      else $error("tie stack count out of range");

   // a pop always has something stacked
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> count_ff != '0)
      else $error("pop from empty tie stack");

   // a response never flags both full and empty
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_full_ff && rsp_empty_ff))
      else $error("response flags full and empty together");

   // free-list head is a slot or nil
   a_free_head: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= NIL_LINK)
      else $error("free-list head out of range");

endmodule
`default_nettype wire
